// ===== design/sch_pkg.sv =====
package sch_pkg;

    localparam int MAX_BLOCKS  = 64;
    localparam int BLOCK_SHIFT = 6;
    localparam int NCATS       = 1 << BLOCK_SHIFT;
    localparam int CAT_W       = 32;
    localparam int CNT_W       = 32;
    localparam int KIND_W      = 2;
    localparam int KEY_W       = CAT_W - BLOCK_SHIFT + 1;
    localparam int SLOT_W      = $clog2(MAX_BLOCKS);
    localparam int USED_W      = $clog2(MAX_BLOCKS + 1);
    localparam int OFF_W       = BLOCK_SHIFT;
    localparam int CUR_W       = OFF_W + 1;
    localparam int ADDR_W      = SLOT_W + OFF_W;

    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic signed [CAT_W-1:0] t_cat;
    typedef logic [CNT_W-1:0]        t_cnt;

    typedef enum logic [KIND_W-1:0] {
        KIND_UPDATE = 2'd0,
        KIND_FIND   = 2'd1,
        KIND_REWIND = 2'd2,
        KIND_NEXT   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        SCAN_MATCH = 2'd0,
        SCAN_MIN   = 2'd1,
        SCAN_NEXT  = 2'd2
    } t_scan_mode;

    typedef enum logic [1:0] {
        OSEL_ECHO = 2'd0,
        OSEL_FULL = 2'd1,
        OSEL_FIND = 2'd2,
        OSEL_NEXT = 2'd3
    } t_osel;

    typedef struct packed {
        logic       load;
        logic       scan_init;
        logic       scan_step;
        t_scan_mode mode;
        logic       ctr_rd_upd;
        logic       ctr_wr_inc;
        logic       alloc_init;
        logic       clr_step;
        logic       set_cursor;
        logic       cur_adv;
        logic       ctr_rd_cur;
        logic       out_load;
        t_osel      sel;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  scan_done;
        logic  hit;
        logic  used_zero;
        logic  used_full;
        logic  clr_last;
        logic  cur_end;
        logic  ctr_nz;
        logic  out_free;
    } t_status;

    // block index of a category, negatives rounded as -((-c)>>shift)-1
    function automatic t_key cat_block(input t_cat c);
        logic [CAT_W:0]       m;
        logic [KEY_W-1:0]     q;
        t_key                 r;
        m = -{c[CAT_W-1], c};
        q = KEY_W'(m >> BLOCK_SHIFT);
        if (c[CAT_W-1]) begin
            r = ~q;
        end else begin
            r = KEY_W'(c >>> BLOCK_SHIFT);
        end
        return r;
    endfunction

    function automatic logic [OFF_W-1:0] cat_offset(input t_cat c);
        logic [CAT_W:0]   m;
        logic [OFF_W-1:0] r;
        m = -{c[CAT_W-1], c};
        if (c[CAT_W-1]) begin
            r = ~m[OFF_W-1:0];
        end else begin
            r = c[OFF_W-1:0];
        end
        return r;
    endfunction

    function automatic t_cat join_cat(input t_key k, input logic [OFF_W-1:0] off);
        logic [CAT_W-1:0] base;
        base = {k[CAT_W-BLOCK_SHIFT-1:0], off};
        return base + CAT_W'(k[KEY_W-1]);
    endfunction

endpackage

// ===== design/sch_ctrl.sv =====
module sch_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  sch_pkg::t_status i_status,
    output sch_pkg::t_cmd    o_cmd
);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_DECODE = 13'b0000000000010,
        S_SCAN   = 13'b0000000000100,
        S_CRD    = 13'b0000000001000,
        S_CWR    = 13'b0000000010000,
        S_ALLOC  = 13'b0000000100000,
        S_CLR    = 13'b0000001000000,
        S_ADV    = 13'b0000010000000,
        S_CHK    = 13'b0000100000000,
        S_CWAIT  = 13'b0001000000000,
        S_FIN    = 13'b0010000000000,
        S_SPARE0 = 13'b0100000000000,
        S_SPARE1 = 13'b1000000000000
    } t_state;

    t_state         r_state, n_state;
    sch_pkg::t_osel r_sel, n_sel;
    sch_pkg::t_cmd  cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= sch_pkg::OSEL_ECHO;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        cmd     = '0;
        cmd.sel = r_sel;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    cmd.load = 1'b1;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_status.kind) inside
                    sch_pkg::KIND_UPDATE, sch_pkg::KIND_FIND: begin
                        cmd.scan_init = 1'b1;
                        cmd.mode      = sch_pkg::SCAN_MATCH;
                        n_state       = S_SCAN;
                    end
                    sch_pkg::KIND_REWIND: begin
                        if (i_status.used_zero) begin
                            n_sel   = sch_pkg::OSEL_ECHO;
                            n_state = S_FIN;
                        end else begin
                            cmd.scan_init = 1'b1;
                            cmd.mode      = sch_pkg::SCAN_MIN;
                            n_state       = S_SCAN;
                        end
                    end
                    default: begin
                        if (i_status.used_zero) begin
                            n_sel   = sch_pkg::OSEL_ECHO;
                            n_state = S_FIN;
                        end else begin
                            n_state = S_ADV;
                        end
                    end
                endcase
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (i_status.scan_done) begin
                    n_sel = sch_pkg::OSEL_ECHO;
                    case (i_status.kind)
                        sch_pkg::KIND_UPDATE: begin
                            if (i_status.hit) begin
                                n_state = S_CRD;
                            end else if (i_status.used_full) begin
                                n_sel   = sch_pkg::OSEL_FULL;
                                n_state = S_FIN;
                            end else begin
                                n_state = S_ALLOC;
                            end
                        end
                        sch_pkg::KIND_FIND: begin
                            n_state = i_status.hit ? S_CRD : S_FIN;
                        end
                        sch_pkg::KIND_REWIND: begin
                            cmd.set_cursor = 1'b1;
                            n_state        = S_FIN;
                        end
                        default: begin
                            if (i_status.hit) begin
                                cmd.set_cursor = 1'b1;
                                n_state        = S_ADV;
                            end else begin
                                n_state = S_FIN;
                            end
                        end
                    endcase
                end
            end
            S_CRD: begin
                cmd.ctr_rd_upd = 1'b1;
                if (i_status.kind == sch_pkg::KIND_UPDATE) begin
                    n_state = S_CWR;
                end else begin
                    n_sel   = sch_pkg::OSEL_FIND;
                    n_state = S_FIN;
                end
            end
            S_CWR: begin
                cmd.ctr_wr_inc = 1'b1;
                n_sel          = sch_pkg::OSEL_ECHO;
                n_state        = S_FIN;
            end
            S_ALLOC: begin
                cmd.alloc_init = 1'b1;
                n_state        = S_CLR;
            end
            S_CLR: begin
                cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_sel   = sch_pkg::OSEL_ECHO;
                    n_state = S_FIN;
                end
            end
            S_ADV: begin
                cmd.cur_adv = 1'b1;
                n_state     = S_CHK;
            end
            S_CHK: begin
                if (i_status.cur_end) begin
                    cmd.scan_init = 1'b1;
                    cmd.mode      = sch_pkg::SCAN_NEXT;
                    n_state       = S_SCAN;
                end else begin
                    cmd.ctr_rd_cur = 1'b1;
                    n_state        = S_CWAIT;
                end
            end
            S_CWAIT: begin
                if (i_status.ctr_nz) begin
                    n_sel   = sch_pkg::OSEL_NEXT;
                    n_state = S_FIN;
                end else begin
                    n_state = S_ADV;
                end
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cmd           = cmd;

endmodule

// ===== design/sch_dp.sv =====
module sch_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [sch_pkg::KIND_W-1:0] i_kind,
    input  sch_pkg::t_cat    i_category,
    input  logic             i_m_axis_tready,
    input  sch_pkg::t_cmd    i_cmd,
    output sch_pkg::t_status o_status,
    output logic             o_valid,
    output sch_pkg::t_cnt    o_count,
    output sch_pkg::t_cat    o_category,
    output logic             o_found,
    output logic             o_table_full
);

    // key table and counter store
    sch_pkg::t_key  keys [sch_pkg::MAX_BLOCKS];
    sch_pkg::t_cnt  ctrs [sch_pkg::MAX_BLOCKS * sch_pkg::NCATS];

    sch_pkg::t_kind          r_kind;
    sch_pkg::t_cat           r_cat;
    sch_pkg::t_key           r_blk;
    logic [sch_pkg::OFF_W-1:0]  r_off;
    logic [sch_pkg::USED_W-1:0] r_used;
    logic [sch_pkg::SLOT_W-1:0] r_cur_blk;
    logic [sch_pkg::CUR_W-1:0]  r_cur_off;
    sch_pkg::t_key           r_cur_key;
    sch_pkg::t_scan_mode     r_mode;
    logic [sch_pkg::USED_W-1:0] r_scan;
    logic                    r_pend;
    logic [sch_pkg::SLOT_W-1:0] r_pidx;
    sch_pkg::t_key           r_krd;
    logic                    r_hit;
    logic [sch_pkg::SLOT_W-1:0] r_best_idx;
    sch_pkg::t_key           r_best_key;
    logic [sch_pkg::OFF_W-1:0]  r_clr;
    sch_pkg::t_cnt           r_crd;
    logic                    r_ovalid;
    sch_pkg::t_cnt           r_ocount;
    sch_pkg::t_cat           r_ocat;
    logic                    r_ofound;
    logic                    r_ofull;

    logic                    issue;
    logic                    better;
    logic [sch_pkg::ADDR_W-1:0] rd_addr;
    sch_pkg::t_cnt           sat_inc;

    assign issue   = i_cmd.scan_step && (r_scan < r_used);
    assign rd_addr = i_cmd.ctr_rd_cur ? {r_cur_blk, r_cur_off[sch_pkg::OFF_W-1:0]}
                                      : {r_best_idx, r_off};
    assign sat_inc = (r_crd == '1) ? r_crd : r_crd + 1'b1;

    always_comb begin
        case (r_mode)
            sch_pkg::SCAN_MATCH: better = (r_krd == r_blk);
            sch_pkg::SCAN_MIN:   better = !r_hit || (r_krd < r_best_key);
            default:             better = (r_krd > r_cur_key)
                                          && (!r_hit || (r_krd < r_best_key));
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_cur_blk <= '0;
            r_cur_off <= '1;
            r_pend    <= 1'b0;
            r_scan    <= '0;
            r_hit     <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cmd.scan_init) begin
                r_scan <= '0;
                r_pend <= 1'b0;
                r_hit  <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_pend <= issue;
                if (issue) begin
                    r_scan <= r_scan + 1'b1;
                end
                if (r_pend && better) begin
                    r_hit <= 1'b1;
                end
            end
            if (i_cmd.clr_step && (r_clr == '1)) begin
                r_used <= r_used + 1'b1;
            end
            if (i_cmd.set_cursor) begin
                r_cur_blk <= r_best_idx;
                r_cur_off <= '1;
            end else if (i_cmd.cur_adv && (r_cur_off != sch_pkg::CUR_W'(sch_pkg::NCATS))) begin
                // before-first wraps to offset zero
                r_cur_off <= r_cur_off + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= sch_pkg::t_kind'(i_kind);
            r_cat  <= i_category;
            r_blk  <= sch_pkg::cat_block(i_category);
            r_off  <= sch_pkg::cat_offset(i_category);
        end
        if (i_cmd.scan_init) begin
            r_mode <= i_cmd.mode;
        end
        r_pidx <= r_scan[sch_pkg::SLOT_W-1:0];
        if (i_cmd.scan_step && r_pend && better) begin
            r_best_idx <= r_pidx;
            r_best_key <= r_krd;
        end
        if (i_cmd.set_cursor) begin
            r_cur_key <= r_best_key;
        end else if (i_cmd.alloc_init && (r_used == '0)) begin
            r_cur_key <= r_blk;
        end
        if (i_cmd.alloc_init) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + 1'b1;
        end
        if (i_cmd.out_load) begin
            r_ocount <= '0;
            r_ocat   <= r_cat;
            r_ofound <= 1'b0;
            r_ofull  <= 1'b0;
            case (i_cmd.sel)
                sch_pkg::OSEL_FULL: r_ofull <= 1'b1;
                sch_pkg::OSEL_FIND: begin
                    r_ocount <= r_crd;
                    r_ofound <= (r_crd != '0);
                end
                sch_pkg::OSEL_NEXT: begin
                    r_ocount <= r_crd;
                    r_ocat   <= sch_pkg::join_cat(r_cur_key, r_cur_off[sch_pkg::OFF_W-1:0]);
                    r_ofound <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_krd <= keys[r_scan[sch_pkg::SLOT_W-1:0]];
        if (i_cmd.alloc_init) begin
            keys[r_used[sch_pkg::SLOT_W-1:0]] <= r_blk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ctr_rd_upd || i_cmd.ctr_rd_cur) begin
            r_crd <= ctrs[rd_addr];
        end
        if (i_cmd.clr_step) begin
            ctrs[{r_used[sch_pkg::SLOT_W-1:0], r_clr}] <=
                (r_clr == r_off) ? sch_pkg::t_cnt'(1) : '0;
        end else if (i_cmd.ctr_wr_inc) begin
            ctrs[{r_best_idx, r_off}] <= sat_inc;
        end
    end

    assign o_status.kind      = r_kind;
    assign o_status.scan_done = !r_pend && (r_scan >= r_used);
    assign o_status.hit       = r_hit;
    assign o_status.used_zero = (r_used == '0);
    assign o_status.used_full = (r_used == sch_pkg::USED_W'(sch_pkg::MAX_BLOCKS));
    assign o_status.clr_last  = (r_clr == '1);
    assign o_status.cur_end   = (r_cur_off == sch_pkg::CUR_W'(sch_pkg::NCATS));
    assign o_status.ctr_nz    = (r_crd != '0);
    assign o_status.out_free  = !r_ovalid || i_m_axis_tready;

    assign o_valid      = r_ovalid;
    assign o_count      = r_ocount;
    assign o_category   = r_ocat;
    assign o_found      = r_ofound;
    assign o_table_full = r_ofull;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= sch_pkg::USED_W'(sch_pkg::MAX_BLOCKS))
        else $error("block count beyond table size");

    a_alloc_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.clr_step && r_clr == '1) |=> (r_used == $past(r_used) + 1'b1))
        else $error("allocation did not add a block");

    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_off <= sch_pkg::CUR_W'(sch_pkg::NCATS)) || (r_cur_off == '1))
        else $error("cursor offset out of range");

    a_pend_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (sch_pkg::USED_W'(r_pidx) < r_used))
        else $error("scan compared an unused slot");

endmodule

// ===== design/sparse_category_histogram.sv =====
// update scans the key table for the block, then bumps its counter, allocates and clears a new block,
// or reports a full table; find scans and reads the counter on a hit; rewind scans for the smallest
// key; next advances the cursor one offset at a time and, at a block end, scans for the next larger key
// one item at a time; the next beat is taken while a result waits on the output
// reset: synchronous active low, empties the key table and parks the cursor
module sparse_category_histogram (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // category
    input  logic [1:0]  i_s_axis_tuser,  // kind
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,  // count, category_out
    output logic [1:0]  o_m_axis_tuser   // found, table_full
);

    sch_pkg::t_cmd    cmd;
    sch_pkg::t_status status;
    sch_pkg::t_cnt    count;
    sch_pkg::t_cat    category_out;
    logic             found;
    logic             table_full;

    sch_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_status        (status),
        .o_cmd           (cmd)
    );

    sch_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_kind          (i_s_axis_tuser),
        .i_category      (i_s_axis_tdata),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_valid         (o_m_axis_tvalid),
        .o_count         (count),
        .o_category      (category_out),
        .o_found         (found),
        .o_table_full    (table_full)
    );

    assign o_m_axis_tdata = {category_out, count};
    assign o_m_axis_tuser = {table_full, found};

endmodule

// ===== tb/sv/sparse_category_histogram_tb.sv =====
module sparse_category_histogram_tb;

    typedef struct {
        logic [31:0] count;
        logic [31:0] category;
        logic        found;
        logic        table_full;
    } t_hist_result;

    localparam int CYCLE_LIMIT = 20000000;
    localparam int POOL_SIZE   = 80;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;  // category
    logic [1:0]  i_s_axis_tuser = '0;  // kind
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [63:0] o_m_axis_tdata;       // count, category_out
    logic [1:0]  o_m_axis_tuser;       // found, table_full

    // shadow copy of the histogram
    longint      shadow_keys [sch_pkg::MAX_BLOCKS];
    logic [31:0] shadow_counts [sch_pkg::MAX_BLOCKS*sch_pkg::NCATS];
    int          shadow_used = 0;
    int          shadow_cur_block = 0;
    int          shadow_cur_offset = -1;

    t_hist_result expected_results [$];
    longint       key_pool [POOL_SIZE];

    int  errors = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  found_seen = 0;
    int  full_seen = 0;
    int  cycle_count = 0;
    int  hold_reqs = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    bit  steady = 1'b0;

    sparse_category_histogram dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(99);
        if (steady || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 5);
    endfunction

    function automatic void split_category(input longint c, output longint blk,
                                           output int off);
        longint q;
        if (c < 0) begin
            q = (-c) >>> sch_pkg::BLOCK_SHIFT;
            blk = -q - 1;
            off = int'(c + ((q + 1) <<< sch_pkg::BLOCK_SHIFT) - 1);
        end else begin
            blk = c >>> sch_pkg::BLOCK_SHIFT;
            off = int'(c & (sch_pkg::NCATS - 1));
        end
    endfunction

    function automatic logic [31:0] join_category(input longint blk, input int off);
        longint c;
        if (blk < 0) begin
            c = -((-blk) <<< sch_pkg::BLOCK_SHIFT) + off + 1;
        end else begin
            c = (blk <<< sch_pkg::BLOCK_SHIFT) + off;
        end
        return c[31:0];
    endfunction

    function automatic int lookup_slot(input longint blk);
        for (int i = 0; i < shadow_used; i++) begin
            if (shadow_keys[i] == blk) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic int following_slot();
        int     best;
        longint cur;
        best = -1;
        cur = shadow_keys[shadow_cur_block];
        for (int i = 0; i < shadow_used; i++) begin
            if (shadow_keys[i] > cur && (best < 0 || shadow_keys[i] < shadow_keys[best])) begin
                best = i;
            end
        end
        return best;
    endfunction

    function automatic t_hist_result predict_histogram(input sch_pkg::t_kind kind,
                                                       input logic [31:0] cat);
        t_hist_result r;
        longint       blk;
        int           off;
        int           s;
        int           best;
        logic [31:0]  v;
        bit           done;
        r.count = '0;
        r.category = cat;
        r.found = 1'b0;
        r.table_full = 1'b0;
        split_category(longint'($signed(cat)), blk, off);
        case (kind)
            sch_pkg::KIND_UPDATE: begin
                s = lookup_slot(blk);
                if (s >= 0) begin
                    if (shadow_counts[s*sch_pkg::NCATS+off] != 32'hFFFF_FFFF) begin
                        shadow_counts[s*sch_pkg::NCATS+off]++;
                    end
                end else if (shadow_used < sch_pkg::MAX_BLOCKS) begin
                    shadow_keys[shadow_used] = blk;
                    for (int i = 0; i < sch_pkg::NCATS; i++) begin
                        shadow_counts[shadow_used*sch_pkg::NCATS+i] = '0;
                    end
                    shadow_counts[shadow_used*sch_pkg::NCATS+off] = 1;
                    shadow_used++;
                end else begin
                    r.table_full = 1'b1;
                end
            end
            sch_pkg::KIND_FIND: begin
                s = lookup_slot(blk);
                if (s >= 0) begin
                    r.count = shadow_counts[s*sch_pkg::NCATS+off];
                    r.found = r.count != 0;
                end
            end
            sch_pkg::KIND_REWIND: begin
                if (shadow_used > 0) begin
                    best = 0;
                    for (int i = 1; i < shadow_used; i++) begin
                        if (shadow_keys[i] < shadow_keys[best]) begin
                            best = i;
                        end
                    end
                    shadow_cur_block = best;
                    shadow_cur_offset = -1;
                end
            end
            default: begin
                done = shadow_used == 0;
                while (!done) begin
                    if (shadow_cur_offset < sch_pkg::NCATS) begin
                        shadow_cur_offset++;
                    end
                    if (shadow_cur_offset >= sch_pkg::NCATS) begin
                        // end of this block, hop to the next larger key
                        shadow_cur_offset = sch_pkg::NCATS;
                        s = following_slot();
                        if (s < 0) begin
                            done = 1'b1;
                        end else begin
                            shadow_cur_block = s;
                            shadow_cur_offset = -1;
                        end
                    end else begin
                        v = shadow_counts[shadow_cur_block*sch_pkg::NCATS+shadow_cur_offset];
                        if (v != 0) begin
                            r.count = v;
                            r.category = join_category(shadow_keys[shadow_cur_block],
                                                       shadow_cur_offset);
                            r.found = 1'b1;
                            done = 1'b1;
                        end
                    end
                end
            end
        endcase
        return r;
    endfunction

    task automatic send_item(input sch_pkg::t_kind kind, input logic [31:0] cat);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= cat;
        i_s_axis_tuser <= kind;
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        expected_results.push_back(predict_histogram(kind, cat));
        items_sent++;
        gap = idle_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // result sink: random stalls, plus long holds on request
    always @(posedge i_clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (steady) begin
            i_m_axis_tready <= 1'b1;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) < 70) ||
                               ($urandom_range(99) < 3 ? 1'b0 : 1'b0);
        end
    end

    always @(posedge i_clk) begin
        t_hist_result e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (o_m_axis_tdata[31:0] !== e.count) begin
                    $error("count: expected %0d, got %0d", e.count, o_m_axis_tdata[31:0]);
                    errors++;
                end
                if (o_m_axis_tdata[63:32] !== e.category) begin
                    $error("category_out: expected %0d, got %0d",
                           $signed(e.category), $signed(o_m_axis_tdata[63:32]));
                    errors++;
                end
                if (o_m_axis_tuser[0] !== e.found) begin
                    $error("found: expected %0b, got %0b", e.found, o_m_axis_tuser[0]);
                    errors++;
                end
                if (o_m_axis_tuser[1] !== e.table_full) begin
                    $error("table_full: expected %0b, got %0b",
                           e.table_full, o_m_axis_tuser[1]);
                    errors++;
                end
                found_seen += e.found;
                full_seen += e.table_full;
            end
        end
    end

    task automatic test_empty_table();
        send_item(sch_pkg::KIND_NEXT, 32'd5);
        send_item(sch_pkg::KIND_REWIND, 32'hFFFF_FFFF);
        send_item(sch_pkg::KIND_FIND, 32'd0);
        send_item(sch_pkg::KIND_NEXT, 32'h8000_0000);
    endtask

    task automatic test_extremes();
        logic [31:0] cats [10];
        cats = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd63,
                 32'd64, 32'hFFFF_FFC0, 32'hFFFF_FFBF, 32'h8000_003F, 32'h7FFF_FFC0};
        foreach (cats[i]) send_item(sch_pkg::KIND_UPDATE, cats[i]);
        send_item(sch_pkg::KIND_UPDATE, 32'd0);
        send_item(sch_pkg::KIND_FIND, 32'd0);
        send_item(sch_pkg::KIND_FIND, 32'h8000_0000);
        send_item(sch_pkg::KIND_FIND, 32'd1);
        send_item(sch_pkg::KIND_FIND, 32'h1234_5678);
    endtask

    task automatic test_walk();
        // next without a rewind first, then a full walk and past the end
        repeat (3) send_item(sch_pkg::KIND_NEXT, 32'd0);
        send_item(sch_pkg::KIND_REWIND, 32'd7);
        repeat (12) send_item(sch_pkg::KIND_NEXT, 32'd0);
        send_item(sch_pkg::KIND_UPDATE, 32'd1000);
        send_item(sch_pkg::KIND_NEXT, 32'd0);
        drain();
    endtask

    function automatic logic [31:0] pick_category();
        if ($urandom_range(99) < 85) begin
            return join_category(key_pool[$urandom_range(POOL_SIZE-1)],
                                 $urandom_range(sch_pkg::NCATS-1));
        end
        return $urandom;
    endfunction

    task automatic test_random(input int n);
        int r;
        for (int i = 0; i < n; i++) begin
            if (i % 400 == 200) steady = 1'b1;
            if (i % 400 == 260) steady = 1'b0;
            r = $urandom_range(99);
            if (r < 50) begin
                send_item(sch_pkg::KIND_UPDATE, pick_category());
            end else if (r < 70) begin
                send_item(sch_pkg::KIND_FIND, pick_category());
            end else if (r < 94) begin
                send_item(sch_pkg::KIND_NEXT, $urandom);
            end else begin
                send_item(sch_pkg::KIND_REWIND, $urandom);
            end
        end
        drain();
    endtask

    task automatic test_backpressure();
        hold_reqs++;
        for (int i = 0; i < 12; i++) begin
            send_item(i % 3 == 0 ? sch_pkg::KIND_FIND : sch_pkg::KIND_UPDATE, pick_category());
        end
        drain();
    endtask

    initial begin
        key_pool[0] = -(longint'(1) <<< 25);
        key_pool[1] = (longint'(1) <<< 25) - 1;
        key_pool[2] = 0;
        key_pool[3] = -1;
        for (int i = 4; i < POOL_SIZE; i++) begin
            key_pool[i] = longint'($signed(26'($urandom)));
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_table();
        test_extremes();
        test_walk();
        test_backpressure();
        test_random(2000);
        test_backpressure();
        repeat (200) @(posedge i_clk);
        $display("%0d items sent, %0d results checked, %0d with a category found,",
                 items_sent, results_seen, found_seen);
        $display("%0d updates refused on a full key table", full_seen);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
